// ===== rtl/bdac_pkg.sv =====
// Package for the binary to decimal ASCII converter.
// Holds widths, constants and the controller/datapath command and status types.
// No dependencies.
package bdac_pkg;

  // Field and storage widths.
  localparam int ValueWidth = 32;
  localparam int NumDigits  = 10;
  localparam int BcdWidth   = 4 * NumDigits;
  localparam int CharWidth  = 6;
  localparam int StepWidth  = 5;
  localparam int RemWidth   = 4;

  // ASCII code of the character '0'.
  localparam logic [CharWidth-1:0] AsciiZero = 6'd48;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // Capture a new value and clear the BCD register.
    logic step;   // One add-3 and shift step of the conversion.
    logic skip;   // Drop a leading zero digit.
    logic emit;   // Present the top digit and shift it out.
  } bdac_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic step_last;  // The current step is the final conversion step.
    logic top_zero;   // The most significant remaining digit is zero.
    logic rem_one;    // Only one digit remains.
  } bdac_sts_t;

endpackage

// ===== rtl/bdac_datapath.sv =====
// Datapath of the binary to decimal ASCII converter.
// Holds the binary and BCD shift registers and the step and digit counters.
// Depends on bdac_pkg.
module bdac_datapath import bdac_pkg::*; (
  input  logic                  clk_i,
  input  logic [ValueWidth-1:0] value_i,
  input  bdac_cmd_t             cmd_i,
  output bdac_sts_t             sts_o,
  output logic [CharWidth-1:0]  digit_char_o,
  output logic                  last_o
);

  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0]   bcd_q, bcd_d;
  logic [StepWidth-1:0]  cnt_q, cnt_d;
  logic [RemWidth-1:0]   rem_q, rem_d;
  logic [BcdWidth-1:0]   bcd_adj;

  // Add 3 to every BCD digit that is 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // Next values of the shift registers and counters.
  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = '0;
      rem_d = RemWidth'(NumDigits);
    end else if (cmd_i.step) begin
      bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
      bin_d = {bin_q[ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.skip || cmd_i.emit) begin
      bcd_d = {bcd_q[BcdWidth-5:0], 4'd0};
      rem_d = rem_q - 1'b1;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
    rem_q <= rem_d;
  end

  // Status for the controller.
  assign sts_o.step_last = (cnt_q == {StepWidth{1'b1}});
  assign sts_o.top_zero  = (bcd_q[BcdWidth-1 -: 4] == 4'd0);
  assign sts_o.rem_one   = (rem_q == RemWidth'(1));

  // The top digit as an ASCII character.
  assign digit_char_o = AsciiZero + {2'b00, bcd_q[BcdWidth-1 -: 4]};
  assign last_o       = sts_o.rem_one;

endmodule

// ===== rtl/bdac_ctrl.sv =====
// Controller of the binary to decimal ASCII converter.
// Sequences load, conversion steps, leading zero removal and digit output.
// Depends on bdac_pkg.
module bdac_ctrl import bdac_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  bdac_sts_t sts_i,
  output bdac_cmd_t cmd_o,
  output logic      busy_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StTrim = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.step = 1'b1;
        if (sts_i.step_last) begin
          state_d = StTrim;
        end
      end
      StTrim: begin
        // Leading zeros go, but the ones digit always stays.
        if (sts_i.top_zero && !sts_i.rem_one) begin
          cmd_o.skip = 1'b1;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (sts_i.rem_one) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

`ifndef SYNTHESIS
  // An accepted item makes the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("converter not busy after an item was accepted");

  // The final digit of an item returns the block to idle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && sts_i.rem_one) |=> !busy_o)
    else $error("converter still busy after the final digit");

  // The final conversion step leads to leading zero removal.
  a_conv_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv && sts_i.step_last) |=> (state_q == StTrim))
    else $error("conversion did not end after the final step");
`endif

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
// Joins the controller and the datapath. Depends on bdac_pkg, bdac_ctrl and
// bdac_datapath.
//
// Usage: present a 32-bit unsigned value on value_i and raise start_i while
// busy_o is low; the item is taken at that clock edge. The block then emits
// the decimal text of the value, most significant digit first and without
// leading zeros, one ASCII character per cycle on digit_char_o, each marked
// by digit_valid_o for exactly one cycle. last_o is high with the least
// significant digit. Zero gives the single character '0'.
// Sequence: the value is loaded at the accepting edge, then come the 32 steps of
// shift-add-3 conversion, then the trim state drops the leading zeros one by
// one, then the digits are emitted. busy_o stays high for the same time for
// every value; a new item may be started in the cycle after the last digit,
// and no new item is taken before the last one is through. The 32-step
// conversion loop takes most of the time of each item.
// Reset returns the controller to idle; any item in progress is dropped.
// The receiver cannot stall: each character is valid for one cycle only.
module binary_to_decimal_ascii import bdac_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  digit_valid_o,
  output logic [CharWidth-1:0]  digit_char_o,
  output logic                  last_o
);

  bdac_cmd_t cmd;
  bdac_sts_t sts;
  logic      dp_last;

  // Sequencing.
  bdac_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Conversion registers.
  bdac_datapath u_datapath (
    .clk_i        (clk_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .digit_char_o (digit_char_o),
    .last_o       (dp_last)
  );

  // A character leaves only while the controller emits.
  assign digit_valid_o = cmd.emit;
  assign last_o        = cmd.emit & dp_last;

endmodule

// ===== tb/sv/binary_to_decimal_ascii_test.sv =====
`timescale 1ns / 1ps
// Testbench for the binary to decimal ASCII converter, checked against its own digit predictor.
// Depends on bdac_pkg and binary_to_decimal_ascii.
module binary_to_decimal_ascii_test;
  import bdac_pkg::*;

  localparam int DecBase     = 10;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 60;
  localparam int ResetCycles = 6;

  // Powers of ten from 1 up to 10^10, the first one above the largest 32-bit value.
  localparam longint unsigned Pow10 [11] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000
  };

  typedef struct {
    logic [CharWidth-1:0] ch;
    logic                 last;
  } digit_item_t;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start_i = 1'b0;
  logic [ValueWidth-1:0] value_i = '0;
  logic                  busy_o;
  logic                  digit_valid_o;
  logic [CharWidth-1:0]  digit_char_o;
  logic                  last_o;

  digit_item_t expected_digits [$];
  int          error_count  = 0;
  int          stall_cycles = 0;
  bit          idle_enable  = 1'b1;

  binary_to_decimal_ascii dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .digit_valid_o (digit_valid_o),
    .digit_char_o  (digit_char_o),
    .last_o        (last_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the decimal characters of one value, most significant first.
  function automatic void predict_decimal_digits(input logic [ValueWidth-1:0] value);
    logic [ValueWidth-1:0] rest;
    logic [3:0]            digits [NumDigits];
    int                    count;
    digit_item_t           item;
    rest  = value;
    count = 0;
    do begin
      digits[count] = 4'(rest % DecBase);
      rest          = rest / DecBase;
      count++;
    end while (rest != 0 && count < NumDigits);
    for (int k = count - 1; k >= 0; k--) begin
      item.ch   = AsciiZero + CharWidth'(digits[k]);
      item.last = (k == 0);
      expected_digits.push_back(item);
    end
  endfunction

  // Present one item, with an optional idle burst first, and wait until it is taken.
  task automatic send_value(input logic [ValueWidth-1:0] value);
    int idle_mode;
    idle_mode = idle_enable ? $urandom_range(0, 3) : 0;
    if (idle_mode != 0) begin
      start_i <= 1'b0;
      value_i <= $urandom();
      // Sometimes let the block finish first so the gap lands on an idle block.
      if (idle_mode == 3) begin
        @(posedge clk_i);
        while (busy_o) @(posedge clk_i);
      end
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= value;
    do @(posedge clk_i); while (busy_o);
    predict_decimal_digits(value);
  endtask

  // Field extremes, values of one, two, three, six, nine and ten digits and the zero value.
  task automatic test_directed_values();
    logic [ValueWidth-1:0] values [$];
    values = {32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1234567890,
              32'd999999999, 32'd1000000000, 32'd4294967295, 32'd4294967294,
              32'd4294967290, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5555_5555,
              32'hAAAA_AAAA, 32'd100000, 32'd909090909, 32'd3876543210, 32'd0};
    foreach (values[i]) send_value(values[i]);
  endtask

  // Random values spread over digit counts, powers of ten, bit patterns and extremes.
  task automatic test_random_values(input int count);
    logic [ValueWidth-1:0] value;
    int                    digits;
    longint unsigned       low;
    longint unsigned       high;
    longint signed         near;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 5))
        0: value = $urandom();
        1: begin
          digits = $urandom_range(1, NumDigits);
          low    = (digits == 1) ? 0 : Pow10[digits-1];
          high   = Pow10[digits] - 1;
          if (high > 64'hFFFF_FFFF) high = 64'hFFFF_FFFF;
          value  = $urandom_range(32'(high), 32'(low));
        end
        2: begin
          near = longint'(Pow10[$urandom_range(0, NumDigits - 1)]) +
                 longint'($urandom_range(0, 4)) - 2;
          value = (near < 0) ? '0 : ValueWidth'(near);
        end
        3: begin
          value = ValueWidth'(1) << $urandom_range(0, ValueWidth - 1);
          if ($urandom_range(0, 1) == 1) value = ~value;
        end
        4: value = $urandom_range(0, 20);
        default: value = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
      send_value(value);
    end
  endtask

  // Items back to back with no idling at all.
  task automatic test_back_to_back(input int count);
    idle_enable = 1'b0;
    for (int n = 0; n < count; n++) send_value($urandom());
  endtask

  // Compare each character with the oldest expectation.
  always @(posedge clk_i) begin : check_digits
    digit_item_t want;
    if (rst_ni && digit_valid_o) begin
      if (expected_digits.size() == 0) begin
        $display("%0t: unexpected digit, actual char %0d last %0b",
                 $time, digit_char_o, last_o);
        error_count++;
      end else begin
        want = expected_digits.pop_front();
        if (digit_char_o !== want.ch) begin
          $display("%0t: digit char mismatch, expected %0d actual %0d",
                   $time, want.ch, digit_char_o);
          error_count++;
        end
        if (last_o !== want.last) begin
          $display("%0t: last mismatch, expected %0b actual %0b",
                   $time, want.last, last_o);
          error_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || digit_valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("binary_to_decimal_ascii test failed");
      $finish;
    end
  end

  // Reset once, run the tests in turn, then drain and report.
  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_values();
    test_random_values(170);
    test_back_to_back(20);
    start_i <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && expected_digits.size() == 0) begin
      $display("binary_to_decimal_ascii test passed");
    end else begin
      $display("binary_to_decimal_ascii test failed");
    end
    $finish;
  end

endmodule
